### design/space_vector_pwm_duty_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the duty block checker.
// ----------------------------------------------------------------------------
`ifndef SPACE_VECTOR_PWM_DUTY_MACROS_SVH
`define SPACE_VECTOR_PWM_DUTY_MACROS_SVH

// Implication checked on every rising clock edge out of reset.
`define SVPD_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SVPD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/svpd_pkg.sv
// ----------------------------------------------------------------------------
// svpd_pkg
// Shared constants for the space-vector duty block.
// ----------------------------------------------------------------------------
package svpd_pkg;
  localparam logic [31:0] PI3_Q30   = 32'd1124419809;
  localparam logic [31:0] SQRT3_Q30 = 32'd1859775393;
  localparam logic [15:0] SUPPLY_RESET = 16'd3072;
  localparam logic [15:0] PERIOD_RESET = 16'd100;
  localparam logic        REG_SUPPLY = 1'b0;
  localparam logic        REG_PERIOD = 1'b1;
endpackage

### design/svpd_sine.sv
// ----------------------------------------------------------------------------
// svpd_sine
// Pipelined Taylor sine of an offset inside a 60 degree sector, Q30 out.
// ----------------------------------------------------------------------------
module svpd_sine #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic [ANGLE_BITS:0]   p,
  output logic [31:0]           sin_q30
);
  // constant divides by reciprocal multiply, exact for 32-bit dividends
  localparam logic [32:0] M6      = 33'(((64'd1 << 35) + 64'd5) / 64'd6);
  localparam logic [32:0] M120    = 33'(((64'd1 << 39) + 64'd119) / 64'd120);
  localparam logic [32:0] M5040   = 33'(((64'd1 << 45) + 64'd5039) / 64'd5040);
  localparam logic [32:0] M362880 = 33'(((64'd1 << 51) + 64'd362879) / 64'd362880);

  // stage 0: x
  logic [ANGLE_BITS+31:0] xp;
  logic [31:0] x0;
  always_ff @(posedge clk) begin
    x0 <= 32'(xp >> ANGLE_BITS);
  end
  assign xp = (ANGLE_BITS+32)'(p) * (ANGLE_BITS+32)'(svpd_pkg::PI3_Q30);

  // powers, one multiply per stage
  logic [63:0] m2, m3, m5, m7, m9;
  logic [31:0] x1, x2a, x2b, x2c, x3r, x3a, x3b, x5r, x5a, x7r, x1b, x1c, x1d;
  logic [31:0] x2, x3, x5, x7, x9;
  assign m2 = 64'(x0) * 64'(x0);
  always_ff @(posedge clk) begin
    x2 <= 32'(m2 >> 30);
    x1 <= x0;
  end
  assign m3 = 64'(x2) * 64'(x1);
  always_ff @(posedge clk) begin
    x3 <= 32'(m3 >> 30);
    x2a <= x2;
    x1b <= x1;
  end
  assign m5 = 64'(x3) * 64'(x2a);
  always_ff @(posedge clk) begin
    x5 <= 32'(m5 >> 30);
    x2b <= x2a;
    x3r <= x3;
    x1c <= x1b;
  end
  assign m7 = 64'(x5) * 64'(x2b);
  always_ff @(posedge clk) begin
    x7 <= 32'(m7 >> 30);
    x2c <= x2b;
    x3a <= x3r;
    x5r <= x5;
    x1d <= x1c;
  end
  assign m9 = 64'(x7) * 64'(x2c);
  logic [31:0] x1e;
  always_ff @(posedge clk) begin
    x9 <= 32'(m9 >> 30);
    x7r <= x7;
    x3b <= x3a;
    x5a <= x5r;
    x1e <= x1d;
  end

  // series coefficients
  logic [64:0] d3, d5, d7, d9;
  logic [31:0] x1f, q3, q5, q7, q9;
  assign d3 = 65'(x3b) * 65'(M6);
  assign d5 = 65'(x5a) * 65'(M120);
  assign d7 = 65'(x7r) * 65'(M5040);
  assign d9 = 65'(x9) * 65'(M362880);
  always_ff @(posedge clk) begin
    x1f <= x1e;
    q3  <= 32'(d3 >> 35);
    q5  <= 32'(d5 >> 39);
    q7  <= 32'(d7 >> 45);
    q9  <= 32'(d9 >> 51);
  end

  logic [33:0] pos, neg;
  assign pos = 34'(x1f) + 34'(q5) + 34'(q9);
  assign neg = 34'(q3) + 34'(q7);
  always_ff @(posedge clk) begin
    sin_q30 <= (pos >= neg) ? 32'(pos - neg) : 32'd0;
  end
endmodule

### design/svpd_sqrt_div.sv
// ----------------------------------------------------------------------------
// svpd_sqrt_div
// Pipelined square root and division giving the clamped modulation index.
// ----------------------------------------------------------------------------
module svpd_sqrt_div #(
  parameter int FRAC_BITS = 15
) (
  input  logic                 clk,
  input  logic [15:0]          qmag_in,
  input  logic [15:0]          dmag_in,
  input  logic [15:0]          supply,
  output logic [FRAC_BITS:0]   u_out
);
  localparam int RB = 32;               // root of a 62-bit radicand
  localparam int QB = FRAC_BITS + 2;    // index quotient bits (clamped)
  localparam logic [FRAC_BITS:0] LIMIT =
    (FRAC_BITS+1)'((577 * (64'd1 << FRAC_BITS)) / 1000);

  // stage 0: sum of squares
  logic [32:0] sumsq;
  always_ff @(posedge clk) begin
    sumsq <= 33'(qmag_in * qmag_in) + 33'(dmag_in * dmag_in);
  end

  // sqrt of sumsq << 30: one root bit per stage (32 stages)
  logic [63:0] rem  [RB+1];
  logic [RB-1:0] root [RB+1];
  logic [63:0] rad  [RB+1];
  assign rem[0] = '0;
  assign root[0] = '0;
  assign rad[0] = {1'b0, sumsq, 30'd0};
  for (genvar i = 0; i < RB; i++) begin : g_sq
    logic [65:0] trial, r2;
    logic [63:0] rem_n;
    logic [RB-1:0] root_n;
    always_comb begin
      r2 = {rem[i], rad[i][63:62]};
      trial = {32'd0, root[i], 2'b01};
      if (r2 >= trial) begin
        rem_n = 64'(r2 - trial);
        root_n = {root[i][RB-2:0], 1'b1};
      end else begin
        rem_n = 64'(r2);
        root_n = {root[i][RB-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      rem[i+1]  <= rem_n;
      root[i+1] <= root_n;
      rad[i+1]  <= {rad[i][61:0], 2'b00};
    end
  end

  // u = (r << F) / (supply << 15) = r / (supply << (15-F)) taken as
  // restoring division of N = r << F by D = supply << 15, QB bits, with
  // saturation when the quotient would exceed QB bits.
  localparam int NB = RB + FRAC_BITS;
  logic [NB-1:0] num;
  logic [31:0]   den;
  assign num = NB'(root[RB]) << FRAC_BITS;
  assign den = {1'b0, supply, 15'd0};

  // overflow: N >= D << QB
  logic ovf0;
  assign ovf0 = ((NB+QB+32)'(num) >> QB) >= (NB+QB+32)'(den);

  logic [NB+31:0] prem [QB+1];
  logic [QB-1:0]  quo  [QB+1];
  logic [31:0]    dv   [QB+1];
  logic           ov   [QB+1];
  logic           zs   [QB+1];
  assign prem[0] = (NB+32)'(num);
  assign quo[0] = '0;
  assign dv[0] = den;
  assign ov[0] = ovf0;
  assign zs[0] = (supply == 16'd0);
  for (genvar k = 0; k < QB; k++) begin : g_dv
    localparam int SH = QB - 1 - k;
    logic [NB+QB+31:0] dsh;
    assign dsh = (NB+QB+32)'(dv[k]) << SH;
    always_ff @(posedge clk) begin
      if ((NB+QB+32)'(prem[k]) >= dsh) begin
        prem[k+1] <= (NB+32)'((NB+QB+32)'(prem[k]) - dsh);
        quo[k+1]  <= quo[k] | (QB'(1) << SH);
      end else begin
        prem[k+1] <= prem[k];
        quo[k+1]  <= quo[k];
      end
      dv[k+1] <= dv[k];
      ov[k+1] <= ov[k];
      zs[k+1] <= zs[k];
    end
  end

  // the user must hold supply constant while items are in flight; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (zs[QB] || ov[QB] || (quo[QB] > QB'(LIMIT))) begin
      u_out <= LIMIT;
    end else begin
      u_out <= (FRAC_BITS+1)'(quo[QB]);
    end
  end
endmodule

### design/space_vector_pwm_duty.sv
// ----------------------------------------------------------------------------
// space_vector_pwm_duty
// Seven-segment space-vector PWM compare values from a d/q command and angle.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy is never high, start may be
// driven every cycle. The square root (one bit per stage) and divider
// (one quotient bit per stage) set the depth. Reset clears the valid
// pipeline and loads supply_voltage 3072 and pwm_period 100.
module space_vector_pwm_duty #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] volt_q,
  input  logic signed [15:0] volt_d,
  input  logic [15:0] elec_angle,
  output logic        done,
  output logic [15:0] compare_a,
  output logic [15:0] compare_b,
  output logic [15:0] compare_c,
  output logic [2:0]  sector_num,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int QB = FRAC_BITS + 2;
  localparam int UDEL = 1 + 32 + QB + 1;   // sqrt/div unit latency
  localparam int SDEL = 8;                 // sine unit latency
  localparam int FB = FRAC_BITS;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS-2);
  localparam logic [FB+2:0] ONE = (FB+3)'(1) << FB;

  // ---- configuration registers ----
  // decoded on the word index bit only
  logic [15:0] supply_voltage, pwm_period;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      supply_voltage <= svpd_pkg::SUPPLY_RESET;
      pwm_period     <= svpd_pkg::PERIOD_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == svpd_pkg::REG_SUPPLY) begin
        supply_voltage <= pwdata[15:0];
      end else begin
        pwm_period <= pwdata[15:0];
      end
    end
  end
  assign prdata = (paddr[2] == svpd_pkg::REG_SUPPLY) ? {16'd0, supply_voltage}
                                                     : {16'd0, pwm_period};
  assign busy = 1'b0;

  // ---- front: magnitudes, turned angle, sector, offset ----
  logic [15:0] qmag, dmag;
  assign qmag = volt_q[15] ? 16'(-volt_q) : 16'(volt_q);
  assign dmag = volt_d[15] ? 16'(-volt_d) : 16'(volt_d);
  logic [ANGLE_BITS-1:0] ang;
  assign ang = volt_q[15] ? ANGLE_BITS'(elec_angle) - QUARTER
                          : ANGLE_BITS'(elec_angle) + QUARTER;
  logic [ANGLE_BITS+2:0] a6;
  assign a6 = (ANGLE_BITS+3)'(ang) * (ANGLE_BITS+3)'(6);
  logic [2:0] sec0;
  assign sec0 = a6[ANGLE_BITS+2:ANGLE_BITS];

  logic [ANGLE_BITS:0] p_r, pc_r;
  logic [2:0] sec_r;
  logic v0;
  always_ff @(posedge clk) begin
    p_r  <= {1'b0, a6[ANGLE_BITS-1:0]};
    pc_r <= ((ANGLE_BITS+1)'(1) << ANGLE_BITS) - {1'b0, a6[ANGLE_BITS-1:0]};
    sec_r <= sec0;
    if (rst) v0 <= 1'b0; else v0 <= start;
  end

  // ---- modulation index ----
  logic [FB:0] u;
  svpd_sqrt_div #(.FRAC_BITS(FB)) u_idx (
    .clk(clk), .qmag_in(qmag), .dmag_in(dmag), .supply(supply_voltage),
    .u_out(u));

  // ---- sines ----
  logic [31:0] s1, s2;
  svpd_sine #(.ANGLE_BITS(ANGLE_BITS)) u_s1 (.clk(clk), .p(pc_r), .sin_q30(s1));
  svpd_sine #(.ANGLE_BITS(ANGLE_BITS)) u_s2 (.clk(clk), .p(p_r), .sin_q30(s2));

  // sqrt3 * sin, then delay to meet u
  logic [31:0] k1, k2;
  always_ff @(posedge clk) begin
    k1 <= 32'((64'(svpd_pkg::SQRT3_Q30) * 64'(s1)) >> 30);
    k2 <= 32'((64'(svpd_pkg::SQRT3_Q30) * 64'(s2)) >> 30);
  end
  // k passes the p register, the sine unit and the k register; u passes the sqrt/div unit.
  localparam int KD = UDEL - SDEL - 2;
  logic [31:0] k1d [KD+1];
  logic [31:0] k2d [KD+1];
  assign k1d[0] = k1;
  assign k2d[0] = k2;
  for (genvar i = 0; i < KD; i++) begin : g_kd
    always_ff @(posedge clk) begin
      k1d[i+1] <= k1d[i];
      k2d[i+1] <= k2d[i];
    end
  end
  // sector and valid delay to meet u
  logic [2:0] secd [UDEL];
  logic       vd   [UDEL];
  assign secd[0] = sec_r;
  assign vd[0] = v0;
  for (genvar i = 0; i < UDEL - 1; i++) begin : g_sd
    always_ff @(posedge clk) begin
      secd[i+1] <= secd[i];
      if (rst) vd[i+1] <= 1'b0; else vd[i+1] <= vd[i];
    end
  end

  // ---- stage A: active times ----
  logic [FB+2:0] t1, t2;
  logic [2:0] sa;
  logic va;
  always_ff @(posedge clk) begin
    t1 <= (FB+3)'((64'(k1d[KD]) * 64'(u)) >> 30);
    t2 <= (FB+3)'((64'(k2d[KD]) * 64'(u)) >> 30);
    sa <= secd[UDEL-1];
    if (rst) va <= 1'b0; else va <= vd[UDEL-1];
  end

  // ---- stage B: phase times ----
  logic [FB+2:0] sum12, t0, h, ta, tb, tc;
  assign sum12 = t1 + t2;
  assign t0 = (sum12 > ONE) ? '0 : ONE - sum12;
  assign h = t0 >> 1;
  always_comb begin
    case (sa)
      3'd0: begin ta = sum12 + h; tb = t2 + h;    tc = h;         end
      3'd1: begin ta = t1 + h;    tb = sum12 + h; tc = h;         end
      3'd2: begin ta = h;         tb = sum12 + h; tc = t2 + h;    end
      3'd3: begin ta = h;         tb = t1 + h;    tc = sum12 + h; end
      3'd4: begin ta = t2 + h;    tb = h;         tc = sum12 + h; end
      default: begin ta = sum12 + h; tb = h;      tc = t1 + h;    end
    endcase
  end
  logic [FB+2:0] ra, rb, rc;
  logic [2:0] sb;
  logic vb;
  always_ff @(posedge clk) begin
    ra <= ta; rb <= tb; rc <= tc;
    sb <= sa + 3'd1;
    if (rst) vb <= 1'b0; else vb <= va;
  end

  // ---- stage C: scale by period ----
  always_ff @(posedge clk) begin
    compare_a <= 16'((64'(pwm_period) * 64'(ra)) >> FB);
    compare_b <= 16'((64'(pwm_period) * 64'(rb)) >> FB);
    compare_c <= 16'((64'(pwm_period) * 64'(rc)) >> FB);
    sector_num <= sb;
    if (rst) done <= 1'b0; else done <= vb;
  end
endmodule

### design/svpd_checker.sv
// ----------------------------------------------------------------------------
// svpd_checker
// Port-level checks for the duty block.
// ----------------------------------------------------------------------------
`include "space_vector_pwm_duty_macros.svh"
module svpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       done,
  input logic [2:0] sector_num,
  input logic       pready
);
  `SVPD_ASSERT_IMPL(a_sector, clk, rst, done, (sector_num >= 3'd1 && sector_num <= 3'd6))
  `SVPD_ASSERT_IMPL(a_ready, clk, rst, 1'b1, pready)
  `SVPD_ASSERT_NEXT(a_nobusy, clk, rst, 1'b1, !busy)
endmodule

bind space_vector_pwm_duty svpd_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .done(done),
  .sector_num(sector_num), .pready(pready));
